>>> rtl/gbnms_pkg.sv
// Shared types and constants for the greedy box suppression block.
`timescale 1ns / 1ps
`default_nettype none

package gbnms_pkg;

  // Sizing of the kept-box store and the per-set box counter
  localparam int MAX_KEPT  = 256;
  localparam int MAX_BOXES = 1024;

  localparam int KEPT_AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int KEPT_CW = $clog2(MAX_KEPT + 1);
  localparam int BOX_CW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

  // Field widths
  localparam int COORD_W   = 14;
  localparam int SIZE_W    = 13;
  localparam int BOX_NUM_W = 10;
  localparam int THR_W     = 16;

  // Arithmetic widths of the overlap test
  localparam int EDGE_W  = COORD_W + 2;      // left + width, signed
  localparam int DIFF_W  = EDGE_W + 1;       // edge difference, signed
  localparam int SPAN_W  = SIZE_W + 1;       // clamped overlap span
  localparam int AREA_W  = 2 * SIZE_W;       // width * height
  localparam int INTER_W = 2 * SPAN_W - 1;   // span product, at most 2^26
  localparam int SUM_W   = AREA_W + 1;       // sum of two areas
  localparam int UNI_W   = SUM_W + 1;        // union, signed
  localparam int PROD_W  = INTER_W + THR_W;  // both sides of the ratio compare

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_IOU_THR = 1'b0;       // word index of the threshold
  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic        [SIZE_W-1:0]  width;
    logic        [SIZE_W-1:0]  height;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // One comparison outcome from the overlap unit
  typedef struct packed {
    logic valid;
    logic hit;
  } iou_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/gbnms_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module gbnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic                                          re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gbnms_iou.sv
// Pipelined overlap-ratio test of the current box against one kept box.
`timescale 1ns / 1ps
`default_nettype none

module gbnms_iou (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              valid_in,
  input  wire gbnms_pkg::box_t                   cur,
  input  wire gbnms_pkg::box_t                   kept,
  input  wire logic [gbnms_pkg::THR_W-1:0]       thr,
  output gbnms_pkg::iou_res_t                    res,
  output logic                                   busy
);

  // stage valids
  logic s1v, s2v, s3v, s4v, s5v;

  // stage 1: edges and areas
  logic signed [gbnms_pkg::EDGE_W-1:0]  ra, rb, ba, bb;
  logic signed [gbnms_pkg::COORD_W-1:0] lb, tb;
  logic        [gbnms_pkg::AREA_W-1:0]  area_a, area_b;
  // stage 2: clamped spans and area sum
  logic [gbnms_pkg::SPAN_W-1:0] iw, ih;
  logic [gbnms_pkg::SUM_W-1:0]  sum2;
  // stage 3: intersection
  logic [gbnms_pkg::INTER_W-1:0] inter3;
  logic [gbnms_pkg::SUM_W-1:0]   sum3;
  // stage 4: union
  logic [gbnms_pkg::INTER_W-1:0]      inter4;
  logic signed [gbnms_pkg::UNI_W-1:0] uni4;
  // stage 5: cross product
  logic [gbnms_pkg::INTER_W-1:0] inter5;
  logic [gbnms_pkg::PROD_W-1:0]  prod5;
  logic                          uni_pos5, uni_zero5;
  // stage 6: outcome
  logic                          res_valid, res_hit;

  // combinational helpers for stage 2
  logic signed [gbnms_pkg::COORD_W-1:0] mx_l, mx_t;
  logic signed [gbnms_pkg::EDGE_W-1:0]  mn_r, mn_b;
  logic signed [gbnms_pkg::DIFF_W-1:0]  dw, dh;

  always_comb begin
    mx_l = (cur.left > lb) ? cur.left : lb;
    mx_t = (cur.top  > tb) ? cur.top  : tb;
    mn_r = (ra < rb) ? ra : rb;
    mn_b = (ba < bb) ? ba : bb;
    dw = gbnms_pkg::DIFF_W'(mn_r) - gbnms_pkg::DIFF_W'(mx_l) + gbnms_pkg::DIFF_W'(1);
    dh = gbnms_pkg::DIFF_W'(mn_b) - gbnms_pkg::DIFF_W'(mx_t) + gbnms_pkg::DIFF_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v       <= 1'b0;
      s2v       <= 1'b0;
      s3v       <= 1'b0;
      s4v       <= 1'b0;
      s5v       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      s1v       <= valid_in;
      s2v       <= s1v;
      s3v       <= s2v;
      s4v       <= s3v;
      s5v       <= s4v;
      res_valid <= s5v;
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    ra <= gbnms_pkg::EDGE_W'(cur.left) + $signed({3'b000, cur.width});
    ba <= gbnms_pkg::EDGE_W'(cur.top)  + $signed({3'b000, cur.height});
    rb <= gbnms_pkg::EDGE_W'(kept.left) + $signed({3'b000, kept.width});
    bb <= gbnms_pkg::EDGE_W'(kept.top)  + $signed({3'b000, kept.height});
    lb <= kept.left;
    tb <= kept.top;
    area_a <= cur.width * cur.height;
    area_b <= kept.width * kept.height;
    // stage 2: drop negative spans to zero
    iw   <= (dw > 0) ? dw[gbnms_pkg::SPAN_W-1:0] : '0;
    ih   <= (dh > 0) ? dh[gbnms_pkg::SPAN_W-1:0] : '0;
    sum2 <= gbnms_pkg::SUM_W'(area_a) + gbnms_pkg::SUM_W'(area_b);
    // stage 3
    inter3 <= gbnms_pkg::INTER_W'(iw * ih);
    sum3   <= sum2;
    // stage 4
    inter4 <= inter3;
    uni4   <= $signed({1'b0, sum3}) - $signed({1'b0, inter3});
    // stage 5
    inter5    <= inter4;
    prod5     <= thr * uni4[gbnms_pkg::SUM_W-1:0];
    uni_pos5  <= (uni4 > 0);
    uni_zero5 <= (uni4 == 0);
    // stage 6: positive union uses the cross product, zero union any overlap, negative union never hits
    if (uni_pos5) begin
      res_hit <= ({inter5, {gbnms_pkg::THR_W{1'b0}}} > prod5);
    end else begin
      res_hit <= uni_zero5 && (inter5 != '0);
    end
  end

  assign res  = '{valid: res_valid, hit: res_hit};
  assign busy = s1v | s2v | s3v | s4v | s5v | res_valid;

endmodule

`default_nettype wire

>>> rtl/greedy_box_nms_top.sv
// Top level of the greedy box suppression block: control, kept store, register port.
//
//   channel   direction  handshake            payload
//   input     in         in_valid/in_ready    first_of_set, box_left, box_top,
//                                             box_width, box_height
//   output    out        out_valid/out_ready  keep, box_number, store_full
//   config    in         APB psel/penable     paddr, pwdata -> prdata
//
// With kept boxes in the set, a result follows acceptance after one store read per
// kept box, the registered store read, the overlap pipeline, a check that the pipeline
// has drained and the closing state; with an empty store, only the check and the closing
// state. The next box can be taken in the same cycle as the result rises, never during a sweep.
// Reset clears control state and restores the default threshold; the store is not cleared.
// A waiting result stalls only the closing cycle of the next box.
`timescale 1ns / 1ps
`default_nettype none

module greedy_box_nms_top (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // input transactions
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  first_of_set,
  input  wire logic signed [gbnms_pkg::COORD_W-1:0]  box_left,
  input  wire logic signed [gbnms_pkg::COORD_W-1:0]  box_top,
  input  wire logic [gbnms_pkg::SIZE_W-1:0]          box_width,
  input  wire logic [gbnms_pkg::SIZE_W-1:0]          box_height,
  // result transactions
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic                                       keep,
  output logic [gbnms_pkg::BOX_NUM_W-1:0]            box_number,
  output logic                                       store_full,
  // register port
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [gbnms_pkg::PADDR_W-1:0]         paddr,
  input  wire logic [gbnms_pkg::PDATA_W-1:0]         pwdata,
  output logic [gbnms_pkg::PDATA_W-1:0]              prdata,
  output logic                                       pready
);

  gbnms_pkg::state_t state, state_next;

  // current box, held for the whole scan
  gbnms_pkg::box_t cur;
  gbnms_pkg::box_t kept_rd;

  logic [gbnms_pkg::THR_W-1:0]   iou_thr;
  logic [gbnms_pkg::KEPT_CW-1:0] kept_count;
  logic [gbnms_pkg::KEPT_CW-1:0] rd_idx;
  logic [gbnms_pkg::BOX_CW-1:0]  box_counter;
  logic                          rd_pend;
  logic                          suppress;

  gbnms_pkg::iou_res_t iou_res;
  logic                iou_busy;

  logic in_take, issue, finish, slot_free, store_room, keep_now;

  // ---------------------------------------------------------------------------
  // Register port: single threshold register, decoded on the word index
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iou_thr <= gbnms_pkg::THR_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[gbnms_pkg::PADDR_W-1] == gbnms_pkg::REG_IOU_THR) begin
      iou_thr <= pwdata[gbnms_pkg::THR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[gbnms_pkg::PADDR_W-1] == gbnms_pkg::REG_IOU_THR) begin
      prdata = gbnms_pkg::PDATA_W'(iou_thr);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: accept, sweep the kept store, then close the transaction
  // ---------------------------------------------------------------------------
  assign slot_free  = !out_valid || out_ready;
  assign store_room = (kept_count != gbnms_pkg::KEPT_CW'(gbnms_pkg::MAX_KEPT));
  assign keep_now   = !suppress;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    case (state)
      gbnms_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = gbnms_pkg::ST_SCAN;
        end
      end
      gbnms_pkg::ST_SCAN: begin
        // one store read per kept box; wait for the pipeline to drain
        if (rd_idx != kept_count) begin
          issue = 1'b1;
        end else if (!rd_pend && !iou_busy) begin
          state_next = gbnms_pkg::ST_DONE;
        end
      end
      gbnms_pkg::ST_DONE: begin
        if (slot_free) begin
          finish     = 1'b1;
          state_next = gbnms_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = gbnms_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbnms_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count  <= '0;
      box_counter <= '0;
      rd_idx      <= '0;
      rd_pend     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_pend <= issue;
      if (in_take) begin
        rd_idx <= '0;
        // start of a new set: empty the store and restart numbering
        if (first_of_set) begin
          kept_count  <= '0;
          box_counter <= '0;
        end
      end else if (issue) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (finish) begin
        if (keep_now && store_room) begin
          kept_count <= kept_count + 1'b1;
        end
        if (box_counter == gbnms_pkg::BOX_CW'(gbnms_pkg::MAX_BOXES - 1)) begin
          box_counter <= '0;
        end else begin
          box_counter <= box_counter + 1'b1;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      cur.left   <= box_left;
      cur.top    <= box_top;
      cur.width  <= box_width;
      cur.height <= box_height;
      suppress   <= 1'b0;
    end else if (iou_res.valid && iou_res.hit) begin
      suppress <= 1'b1;
    end
    if (finish) begin
      keep       <= keep_now;
      store_full <= keep_now && !store_room;
      box_number <= gbnms_pkg::BOX_NUM_W'(box_counter);
    end
  end

  // ---------------------------------------------------------------------------
  // Kept store: written only when a transaction closes, read only during a
  // sweep, so a write and a read of the same entry never overlap
  // ---------------------------------------------------------------------------
  gbnms_ram #(
    .WIDTH (gbnms_pkg::BOX_W),
    .DEPTH (gbnms_pkg::MAX_KEPT)
  ) u_kept_ram (
    .clk   (clk),
    .we    (finish && keep_now && store_room),
    .waddr (kept_count[gbnms_pkg::KEPT_AW-1:0]),
    .wdata (cur),
    .re    (issue),
    .raddr (rd_idx[gbnms_pkg::KEPT_AW-1:0]),
    .rdata (kept_rd)
  );

  // Overlap test, one kept box per cycle
  gbnms_iou u_iou (
    .clk      (clk),
    .rst      (rst),
    .valid_in (rd_pend),
    .cur      (cur),
    .kept     (kept_rd),
    .thr      (iou_thr),
    .res      (iou_res),
    .busy     (iou_busy)
  );

endmodule

`default_nettype wire

>>> rtl/gbnms_chk.sv
// Port-level checks for the greedy box suppression block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module gbnms_chk (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_ready,
  input wire logic                                  out_valid,
  input wire logic                                  out_ready,
  input wire logic                                  keep,
  input wire logic [gbnms_pkg::BOX_NUM_W-1:0]       box_number,
  input wire logic                                  store_full,
  input wire logic                                  pready
);

  // a full-store flag only ever comes with a kept box
  a_full_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && store_full |-> keep)
    else $error("store_full without keep");

  // after an acceptance the input is not ready in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

  // reset leaves the block ready and with no result pending
  a_reset_state: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid && pready)
    else $error("bad state after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(keep) && $stable(box_number)
                                && $stable(store_full))
    else $error("result changed while stalled");

endmodule

bind greedy_box_nms_top gbnms_chk u_gbnms_chk (.*);

`default_nettype wire

>>> bench/greedy_box_nms_top_test.sv
// Self-checking testbench for the greedy box suppression block.
`timescale 1ns / 1ps

module greedy_box_nms_top_test;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 11;
  localparam int TIMEOUT_NS    = 64_000_000;
  localparam int ADDR_STRIDE   = 4;
  localparam int UNMAPPED_REG  = 1;      // first word index with no register behind it
  localparam int CONFIG_SETTLE = 16;
  localparam int FINAL_SETTLE  = gbnms_pkg::MAX_KEPT + 40;

  localparam int COORD_MIN = -(1 << (gbnms_pkg::COORD_W - 1));
  localparam int COORD_MAX = (1 << (gbnms_pkg::COORD_W - 1)) - 1;
  localparam int SIZE_MAX  = (1 << gbnms_pkg::SIZE_W) - 1;

  // Layout of the set that overfills the kept store: disjoint boxes on a grid
  localparam int GRID_ITEMS = 300;
  localparam int GRID_COLS  = 18;
  localparam int GRID_PITCH = 900;

  typedef struct packed {
    logic            first;
    gbnms_pkg::box_t box;
  } box_item_t;

  typedef struct packed {
    logic                            keep;
    logic [gbnms_pkg::BOX_NUM_W-1:0] number;
    logic                            full;
  } verdict_t;

  typedef enum {SHAPE_CLUSTER, SHAPE_SPECK, SHAPE_SCATTER} box_shape_t;
  typedef enum logic [1:0] {RX_OPEN, RX_THIRDS, RX_COIN, RX_BURSTY} rx_mode_t;

  // Tracks the kept list of the current set and the verdicts still owed by the block.
  class verdict_scoreboard;
    logic [gbnms_pkg::THR_W-1:0] iou_limit;
    gbnms_pkg::box_t             kept_list[$];
    int unsigned                 set_position;
    verdict_t                    pending_verdicts[$];
    int unsigned                 errors;

    function new();
      iou_limit    = gbnms_pkg::THR_RESET;
      set_position = 0;
      errors       = 0;
    endfunction

    function void write_register(int idx, logic [gbnms_pkg::PDATA_W-1:0] value);
      if (idx == gbnms_pkg::REG_IOU_THR) begin
        iou_limit = value[gbnms_pkg::THR_W-1:0];
      end
    endfunction

    // Exact intersection-over-union test of new box a against kept box b.
    function bit overlap_too_large(gbnms_pkg::box_t a, gbnms_pkg::box_t b);
      longint a_l, a_t, a_w, a_h, b_l, b_t, b_w, b_h;
      longint span_x, span_y, inter, uni, limit;
      a_l = a.left;
      a_t = a.top;
      a_w = a.width;
      a_h = a.height;
      b_l = b.left;
      b_t = b.top;
      b_w = b.width;
      b_h = b.height;
      limit = iou_limit;
      span_x = ((a_l + a_w < b_l + b_w) ? a_l + a_w : b_l + b_w)
             - ((a_l > b_l) ? a_l : b_l) + 1;
      span_y = ((a_t + a_h < b_t + b_h) ? a_t + a_h : b_t + b_h)
             - ((a_t > b_t) ? a_t : b_t) + 1;
      if (span_x < 0) span_x = 0;
      if (span_y < 0) span_y = 0;
      inter = span_x * span_y;
      uni = a_w * a_h + b_w * b_h - inter;
      if (uni > 0) return (inter << gbnms_pkg::THR_W) > limit * uni;
      return (uni == 0) && (inter > 0);
    endfunction

    function void note_box(box_item_t item);
      verdict_t v;
      if (item.first) begin
        kept_list.delete();
        set_position = 0;
      end
      v.keep = 1'b1;
      v.full = 1'b0;
      foreach (kept_list[k]) begin
        if (overlap_too_large(item.box, kept_list[k])) v.keep = 1'b0;
      end
      if (v.keep) begin
        if (kept_list.size() < gbnms_pkg::MAX_KEPT) kept_list = {kept_list, item.box};
        else v.full = 1'b1;
      end
      v.number = set_position[gbnms_pkg::BOX_NUM_W-1:0];
      set_position++;
      if (set_position >= gbnms_pkg::MAX_BOXES) set_position = 0;
      pending_verdicts = {pending_verdicts, v};
    endfunction

    function void check_verdict(logic got_keep, logic [gbnms_pkg::BOX_NUM_W-1:0] got_number,
                                logic got_full);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result with nothing outstanding: keep %0d, box_number %0d, store_full %0d",
               got_keep, got_number, got_full);
        errors++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (got_keep !== want.keep) begin
        $error("keep: expected %0d, got %0d", want.keep, got_keep);
        errors++;
      end
      if (got_number !== want.number) begin
        $error("box_number: expected %0d, got %0d", want.number, got_number);
        errors++;
      end
      if (got_full !== want.full) begin
        $error("store_full: expected %0d, got %0d", want.full, got_full);
        errors++;
      end
    endfunction
  endclass

  // Every block input starts at a known value
  logic                                 clk          = 1'b0;
  logic                                 rst          = 1'b1;
  logic                                 in_valid     = 1'b0;
  logic                                 in_ready;
  logic                                 first_of_set = 1'b0;
  logic signed [gbnms_pkg::COORD_W-1:0] box_left     = '0;
  logic signed [gbnms_pkg::COORD_W-1:0] box_top      = '0;
  logic [gbnms_pkg::SIZE_W-1:0]         box_width    = '0;
  logic [gbnms_pkg::SIZE_W-1:0]         box_height   = '0;
  logic                                 out_valid;
  logic                                 out_ready    = 1'b0;
  logic                                 keep;
  logic [gbnms_pkg::BOX_NUM_W-1:0]      box_number;
  logic                                 store_full;
  logic                                 psel         = 1'b0;
  logic                                 penable      = 1'b0;
  logic                                 pwrite       = 1'b0;
  logic [gbnms_pkg::PADDR_W-1:0]        paddr        = '0;
  logic [gbnms_pkg::PDATA_W-1:0]        pwdata       = '0;
  logic [gbnms_pkg::PDATA_W-1:0]        prdata;
  logic                                 pready;

  verdict_scoreboard sb = new();
  int                burst_left = 0;
  logic [31:0]       rx_tick = '0;

  greedy_box_nms_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .first_of_set (first_of_set),
    .box_left     (box_left),
    .box_top      (box_top),
    .box_width    (box_width),
    .box_height   (box_height),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .keep         (keep),
    .box_number   (box_number),
    .store_full   (store_full),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(CLK_HALF) clk = ~clk;

  // Receiver: cycle through its own stall modes in turn, so that
  // fully open stretches alternate with regular, random and bursty back-pressure.
  // out_ready only ever changes on the falling edge.
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode_t'(rx_tick[9:8]))
      RX_OPEN:   out_ready <= 1'b1;
      RX_THIRDS: out_ready <= (rx_tick % 3) != 0;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= rx_tick[3:0] < 4'd10;
    endcase
  end

  // Check every result transaction against the oldest outstanding verdict
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_verdict(keep, box_number, store_full);
    end
  end

  // Hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("greedy_box_nms_top_test failed");
    $finish;
  end

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic int jitter(int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic box_item_t box_of(bit first, int l, int t, int w, int h);
    box_item_t item;
    item.first      = first;
    item.box.left   = gbnms_pkg::COORD_W'(l);
    item.box.top    = gbnms_pkg::COORD_W'(t);
    item.box.width  = gbnms_pkg::SIZE_W'(w);
    item.box.height = gbnms_pkg::SIZE_W'(h);
    return item;
  endfunction

  // Cluster boxes sit around a common centre with a common size, so they overlap
  // to varying degrees; specks are near-degenerate boxes for the zero and negative
  // union paths; scatter boxes are uniform over every field.
  function automatic box_item_t shaped_box(bit first, box_shape_t shape, int cx, int cy,
                                           int base_w, int base_h);
    int spread_w, spread_h;
    spread_w = 1 + base_w / 4;
    spread_h = 1 + base_h / 4;
    case (shape)
      SHAPE_CLUSTER:
        return box_of(first,
                      clip(cx + jitter(spread_w), COORD_MIN, COORD_MAX),
                      clip(cy + jitter(spread_h), COORD_MIN, COORD_MAX),
                      clip(base_w + jitter(spread_w), 0, SIZE_MAX),
                      clip(base_h + jitter(spread_h), 0, SIZE_MAX));
      SHAPE_SPECK:
        return box_of(first,
                      clip(cx + jitter(2), COORD_MIN, COORD_MAX),
                      clip(cy + jitter(2), COORD_MIN, COORD_MAX),
                      $urandom_range(0, 2), $urandom_range(0, 2));
      default:
        return box_of(first, $urandom, $urandom, $urandom, $urandom);
    endcase
  endfunction

  function automatic logic [gbnms_pkg::PADDR_W-1:0] reg_address(int idx);
    return gbnms_pkg::PADDR_W'(idx * ADDR_STRIDE);
  endfunction

  // Present one input transaction. The sender works in bursts of random length;
  // between bursts drop valid for a random gap, or carry straight on.
  task automatic send_box(box_item_t item);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    first_of_set <= item.first;
    box_left     <= item.box.left;
    box_top      <= item.box.top;
    box_width    <= item.box.width;
    box_height   <= item.box.height;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_box(item);
  endtask

  // Hold the sender until every outstanding verdict has arrived, then idle a while
  task automatic hold_until_drained(int settle);
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_register(int idx, logic [gbnms_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= reg_address(idx);
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_register(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_threshold();
    logic [gbnms_pkg::PDATA_W-1:0] want;
    want = gbnms_pkg::PDATA_W'(sb.iou_limit);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= reg_address(gbnms_pkg::REG_IOU_THR);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) begin
      $error("threshold register: expected %0d, got %0d", want, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed sets of overlapping boxes, with specks and uniform noise
  // mixed in; now and then hold the sender until the block has caught up.
  task automatic random_sets(int total);
    int remaining, set_len, cx, cy, base_w, base_h, pick;
    box_shape_t shape;
    remaining = total;
    while (remaining > 0) begin
      if ($urandom_range(0, 7) == 0) hold_until_drained(CONFIG_SETTLE);
      set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(31, 80) : $urandom_range(1, 30);
      cx = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
      cy = int'($urandom_range(0, 2 * COORD_MAX + 1)) + COORD_MIN;
      base_w = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 120) : $urandom_range(0, SIZE_MAX);
      base_h = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 120) : $urandom_range(0, SIZE_MAX);
      for (int i = 0; i < set_len && remaining > 0; i++) begin
        pick = $urandom_range(0, 19);
        if (pick < 14) shape = SHAPE_CLUSTER;
        else if (pick < 17) shape = SHAPE_SPECK;
        else shape = SHAPE_SCATTER;
        send_box(shaped_box(i == 0, shape, cx, cy, base_w, base_h));
        remaining--;
      end
    end
  endtask

  // Disjoint boxes survive every test, so the store fills and then overflows;
  // every twelfth box repeats an earlier one and is normally suppressed.
  task automatic fill_kept_store();
    gbnms_pkg::box_t placed[$];
    box_item_t       item;
    int              g;
    g = 0;
    for (int k = 0; k < GRID_ITEMS; k++) begin
      if (k % 12 == 11) begin
        item.first = 1'b0;
        item.box   = placed[$urandom_range(0, placed.size() - 1)];
      end else begin
        item = box_of(k == 0,
                      COORD_MIN + (g % GRID_COLS) * GRID_PITCH,
                      COORD_MIN + (g / GRID_COLS) * GRID_PITCH,
                      $urandom_range(1, GRID_PITCH - 100),
                      $urandom_range(1, GRID_PITCH - 100));
        placed = {placed, item.box};
        g++;
      end
      send_box(item);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Threshold must come out of reset at its default
    read_threshold();

    // Directed: extreme coordinates and sizes at the default threshold
    send_box(box_of(1, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX));
    send_box(box_of(0, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX));
    send_box(box_of(0, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX));
    send_box(box_of(0, COORD_MAX, COORD_MIN, 0, SIZE_MAX));
    send_box(box_of(0, -1, -1, 1, 1));
    // Degenerate boxes: zero union with and without overlap, negative union
    send_box(box_of(1, 0, 0, 1, 1));
    send_box(box_of(0, 0, 0, 0, 0));
    send_box(box_of(0, 5, 5, 0, 0));
    send_box(box_of(0, 5, 5, 0, 0));
    send_box(box_of(0, 100, 100, 0, 0));
    send_box(box_of(0, 120, 120, 0, 0));
    // Partial overlaps either side of the threshold, then an exact repeat
    send_box(box_of(1, 0, 0, 99, 99));
    send_box(box_of(0, 10, 10, 99, 99));
    send_box(box_of(0, 50, 50, 99, 99));
    send_box(box_of(0, -60, -60, 99, 99));
    send_box(box_of(0, 0, 0, 99, 99));

    // A write to a word with no register behind it must leave the threshold alone
    hold_until_drained(CONFIG_SETTLE);
    write_register(UNMAPPED_REG, $urandom);
    read_threshold();

    // Lowest threshold: any real overlap suppresses
    write_register(gbnms_pkg::REG_IOU_THR, '0);
    read_threshold();
    random_sets(100);

    // Highest threshold, with junk in the unused upper data bits
    hold_until_drained(CONFIG_SETTLE);
    write_register(gbnms_pkg::REG_IOU_THR, {16'($urandom), 16'hFFFF});
    read_threshold();
    random_sets(100);

    hold_until_drained(CONFIG_SETTLE);
    write_register(gbnms_pkg::REG_IOU_THR, 32'd32768);
    fill_kept_store();

    repeat (2) begin
      hold_until_drained(CONFIG_SETTLE);
      write_register(gbnms_pkg::REG_IOU_THR, $urandom);
      read_threshold();
      random_sets(115);
    end

    // Let the last verdicts arrive, then allow a full scan more for strays
    hold_until_drained(FINAL_SETTLE);
    if (sb.errors == 0) begin
      $display("greedy_box_nms_top_test passed");
    end else begin
      $display("greedy_box_nms_top_test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/gbnms_pkg.sv
rtl/gbnms_ram.sv
rtl/gbnms_iou.sv
rtl/greedy_box_nms_top.sv
rtl/gbnms_chk.sv
bench/greedy_box_nms_top_test.sv
